>>> rtl/core/rfa_pkg.sv
package rfa_pkg;

  // Operation kinds carried by the input item.
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;
  localparam logic [2:0] KIND_RED = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Comparison codes.
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL0, S_MUL1, S_MUL2, S_FORM, S_GCD_INIT, S_GCD_STEP,
    S_SCALE, S_DIVN_INIT, S_DIVN_STEP, S_DIVN_END, S_DIVD_INIT, S_DIVD_STEP,
    S_DIVD_END, S_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL0, OP_MUL1, OP_MUL2, OP_FORM, OP_GCD_INIT,
    OP_GCD_STEP, OP_SCALE, OP_DIVN_INIT, OP_DIV_STEP, OP_DIVN_END,
    OP_DIVD_INIT, OP_DIVD_END, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       sel_b;
    logic [1:0] status;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       a_zden;
    logic       b_zden;
    logic       b_num_zero;
    logic       rn_zero;
    logic       gcd_done;
  } dp_stat_t;

endpackage

>>> rtl/core/rational_fraction_alu_core.sv
// An arithmetic kind is reduced by a binary GCD loop and then two bit-serial
// divisions of 2*OPERAND_WIDTH steps each, one for the numerator and one for the denominator.
// The reduce-both kind runs that reduction twice, once per operand; errors and compare skip it.
// Throughput: one item at a time; a new item is taken while the last result
// still waits in the output register. Reset (rst_n low, synchronous) returns the
// controller to idle and drops any pending result; no memory is cleared.
module rational_fraction_alu_core
  import rfa_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_order,
  output logic [1:0]         out_status,
  output logic               out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  rfa_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  rfa_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk         (clk),
    .in_kind     (in_kind),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .cmd         (cmd),
    .stat        (stat),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_order   (out_order),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  // A delivered denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != 31'd0)
    else $error("result denominator is zero");

  // An error result always reads zero over one.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_res_num == 32'sd0 && out_res_den == 31'd1)
    else $error("error result is not 0/1");

  // Only a compare result, always the single final one, carries a nonzero order.
  a_order_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order != ORD_LT |-> out_last && out_status == ST_OK)
    else $error("order set on a result that is not a compare");

endmodule

>>> rtl/core/rfa_dp.sv
module rfa_dp
  import rfa_pkg::*;
#(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_order,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int PW = 2 * W;
  localparam int KW = $clog2(PW);
  localparam logic [PW-1:0] LIM = PW'((64'd1 << (W - 1)) - 64'd1);

  // Sign and magnitude of the low W bits of an operand.
  function automatic logic [W:0] split_f(input logic [31:0] x);
    logic [W-1:0] v;
    v = x[W-1:0];
    return v[W-1] ? {1'b1, ~v + 1'b1} : {1'b0, v};
  endfunction

  logic [2:0]    kind_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic          sa_r, sb_r, az_r, bz_r;
  logic [PW-1:0] x_r, y_r, d_r;
  logic [PW-1:0] rn_r, rd_r;
  logic          rneg_r;
  logic [1:0]    order_r;
  logic [PW-1:0] ga_r, gb_r, g_r, q_r;
  logic [KW-1:0] gk_r;
  logic [PW:0]   rem_r;
  logic signed [31:0] res_num_r;
  logic [30:0]   res_den_r;
  logic [1:0]    ord_out_r, st_out_r;
  logic          last_r;

  logic [W:0]    sp_an, sp_ad, sp_bn, sp_bd;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          sy;
  logic [PW:0]   rem_sh;
  logic          div_ge;
  logic [1:0]    emit_st;
  logic [31:0]   mag32;

  assign sp_an = split_f(in_a_num);
  assign sp_ad = split_f(in_a_den);
  assign sp_bn = split_f(in_b_num);
  assign sp_bd = split_f(in_b_den);

  // Shared multiplier; operand pairs follow the step and the kind.
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (cmd.op)
      OP_MUL0: begin
        mul_a = an_r;
        mul_b = (kind_r == KIND_MUL) ? bn_r : bd_r;
      end
      OP_MUL1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      OP_MUL2: begin
        mul_a = ad_r;
        mul_b = (kind_r == KIND_DIV) ? bn_r : bd_r;
      end
      default: ;
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  assign sy     = sb_r ^ (kind_r == KIND_SUB);
  assign rem_sh = {rem_r[PW-1:0], q_r[PW-1]};
  assign div_ge = rem_sh >= {1'b0, g_r};

  // Overflow check and final status of an emitted result.
  always_comb begin
    emit_st = cmd.status;
    if (cmd.status == ST_OK && (rn_r > LIM || rd_r > LIM)) begin
      emit_st = ST_OVF;
    end
  end
  assign mag32 = 32'(rn_r[W-1:0]);

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_kind;
        an_r   <= sp_an[W-1:0];
        ad_r   <= sp_ad[W-1:0];
        bn_r   <= sp_bn[W-1:0];
        bd_r   <= sp_bd[W-1:0];
        sa_r   <= (sp_an[W] ^ sp_ad[W]) && (sp_an[W-1:0] != '0);
        sb_r   <= (sp_bn[W] ^ sp_bd[W]) && (sp_bn[W-1:0] != '0);
        az_r   <= sp_ad[W-1:0] == '0;
        bz_r   <= sp_bd[W-1:0] == '0;
      end
      OP_MUL0: x_r <= prod;
      OP_MUL1: y_r <= prod;
      OP_MUL2: d_r <= prod;
      OP_FORM: begin
        order_r <= ORD_LT;
        case (kind_r)
          KIND_ADD, KIND_SUB: begin
            rd_r <= d_r;
            if (sa_r == sy) begin
              rn_r   <= x_r + y_r;
              rneg_r <= sa_r;
            end else if (x_r >= y_r) begin
              rn_r   <= x_r - y_r;
              rneg_r <= sa_r;
            end else begin
              rn_r   <= y_r - x_r;
              rneg_r <= sy;
            end
          end
          KIND_MUL, KIND_DIV: begin
            rn_r   <= x_r;
            rd_r   <= d_r;
            rneg_r <= sa_r ^ sb_r;
          end
          KIND_CMP: begin
            rn_r   <= '0;
            rd_r   <= PW'(1);
            rneg_r <= 1'b0;
            if (sa_r != sb_r) begin
              order_r <= sa_r ? ORD_LT : ORD_GT;
            end else if (x_r == y_r) begin
              order_r <= ORD_EQ;
            end else if (!sa_r) begin
              order_r <= (x_r < y_r) ? ORD_LT : ORD_GT;
            end else begin
              order_r <= (x_r > y_r) ? ORD_LT : ORD_GT;
            end
          end
          default: begin
            rn_r   <= cmd.sel_b ? PW'(bn_r) : PW'(an_r);
            rd_r   <= cmd.sel_b ? PW'(bd_r) : PW'(ad_r);
            rneg_r <= cmd.sel_b ? sb_r : sa_r;
          end
        endcase
      end
      OP_GCD_INIT: begin
        ga_r <= rn_r;
        gb_r <= rd_r;
        gk_r <= '0;
        if (rn_r == '0) begin
          rd_r   <= PW'(1);
          rneg_r <= 1'b0;
        end
      end
      OP_GCD_STEP: begin
        if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          gk_r <= gk_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          gb_r <= gb_r - ga_r;
        end
      end
      OP_SCALE: g_r <= ga_r << gk_r;
      OP_DIVN_INIT: begin
        q_r   <= rn_r;
        rem_r <= '0;
      end
      OP_DIVD_INIT: begin
        q_r   <= rd_r;
        rem_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? (rem_sh - {1'b0, g_r}) : rem_sh;
        q_r   <= {q_r[PW-2:0], div_ge};
      end
      OP_DIVN_END: rn_r <= q_r;
      OP_DIVD_END: rd_r <= q_r;
      OP_EMIT: begin
        st_out_r <= emit_st;
        last_r   <= cmd.last;
        if (emit_st != ST_OK) begin
          res_num_r <= '0;
          res_den_r <= 31'd1;
          ord_out_r <= ORD_LT;
        end else begin
          res_num_r <= rneg_r ? -mag32 : mag32;
          res_den_r <= 31'(rd_r[W-1:0]);
          ord_out_r <= order_r;
        end
      end
      default: ;
    endcase
  end

  assign stat.kind       = kind_r;
  assign stat.a_zden     = az_r;
  assign stat.b_zden     = bz_r;
  assign stat.b_num_zero = bn_r == '0;
  assign stat.rn_zero    = rn_r == '0;
  assign stat.gcd_done   = ga_r == gb_r;

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_order   = ord_out_r;
  assign out_status  = st_out_r;
  assign out_last    = last_r;

endmodule

>>> rtl/core/rfa_ctrl.sv
module rfa_ctrl
  import rfa_pkg::*;
#(
  parameter int W = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);
  localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

  ctrl_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          second_r, second_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          emit_ok;
  logic          half_zden;

  assign emit_ok   = !out_valid_r || out_ready;
  assign half_zden = second_r ? stat.b_zden : stat.a_zden;

  // Next state and sequencing registers.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    second_nxt    = second_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        second_nxt = 1'b0;
        st_nxt     = ST_OK;
        case (stat.kind) inside
          [KIND_ADD:KIND_CMP]: begin
            if (stat.a_zden || stat.b_zden) begin
              st_nxt    = ST_ZDEN;
              state_nxt = S_EMIT;
            end else if (stat.kind == KIND_DIV && stat.b_num_zero) begin
              st_nxt    = ST_DIV0;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_MUL0;
            end
          end
          KIND_RED: state_nxt = S_FORM;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_FORM;
      S_FORM: begin
        if (stat.kind == KIND_RED) begin
          st_nxt    = half_zden ? ST_ZDEN : ST_OK;
          state_nxt = half_zden ? S_EMIT : S_GCD_INIT;
        end else if (stat.kind == KIND_CMP) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_GCD_INIT;
        end
      end
      S_GCD_INIT: state_nxt = stat.rn_zero ? S_EMIT : S_GCD_STEP;
      S_GCD_STEP: begin
        if (stat.gcd_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: state_nxt = S_DIVN_INIT;
      S_DIVN_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIVN_STEP;
      end
      S_DIVN_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DIVN_END;
        end
      end
      S_DIVN_END: state_nxt = S_DIVD_INIT;
      S_DIVD_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIVD_STEP;
      end
      S_DIVD_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DIVD_END;
        end
      end
      S_DIVD_END: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          if (stat.kind == KIND_RED && !second_r) begin
            second_nxt = 1'b1;
            state_nxt  = S_FORM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.sel_b  = second_r;
    cmd.status = st_r;
    cmd.last   = !(stat.kind == KIND_RED && !second_r);
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_MUL0:      cmd.op = OP_MUL0;
      S_MUL1:      cmd.op = OP_MUL1;
      S_MUL2:      cmd.op = OP_MUL2;
      S_FORM:      cmd.op = OP_FORM;
      S_GCD_INIT:  cmd.op = OP_GCD_INIT;
      S_GCD_STEP:  cmd.op = stat.gcd_done ? OP_NONE : OP_GCD_STEP;
      S_SCALE:     cmd.op = OP_SCALE;
      S_DIVN_INIT: cmd.op = OP_DIVN_INIT;
      S_DIVN_STEP: cmd.op = OP_DIV_STEP;
      S_DIVN_END:  cmd.op = OP_DIVN_END;
      S_DIVD_INIT: cmd.op = OP_DIVD_INIT;
      S_DIVD_STEP: cmd.op = OP_DIV_STEP;
      S_DIVD_END:  cmd.op = OP_DIVD_END;
      S_EMIT:      cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      second_r    <= 1'b0;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      second_r    <= second_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> tb/testbench.sv
// Checks rational_fraction_alu_core transfer by transfer against a behavioral
// predictor built from exact 64-bit fraction arithmetic.
class frac_scoreboard;
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         order;
    logic [1:0]         status;
    logic               last;
  } result_t;

  result_t     pending[$];
  int          errors;
  int          results_seen;
  int          items_seen;
  int          kind_count[8];
  int          status_count[4];

  // Split a 32-bit two's complement value into sign and magnitude.
  static function void to_sign_mag(input logic [31:0] v, output bit neg,
                                   output logic [63:0] mag);
    neg = v[31];
    mag = v[31] ? {32'd0, -v} : {32'd0, v};
  endfunction

  static function logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  static function void simplify(inout bit neg, inout logic [63:0] n,
                                inout logic [63:0] d);
    logic [63:0] g;
    g = gcd64(n, d);
    if (g != 0) begin
      n = n / g;
      d = d / g;
    end
    if (n == 0) begin
      neg = 0;
      d = 1;
    end
  endfunction

  // Returns 0 for a zero denominator.
  static function bit take_operand(input logic [31:0] n, input logic [31:0] d,
                                   output bit neg, output logic [63:0] fn,
                                   output logic [63:0] fd);
    bit nn, dn;
    to_sign_mag(n, nn, fn);
    to_sign_mag(d, dn, fd);
    neg = nn != dn;
    if (fd == 0) begin
      neg = 0;
      fn = 0;
      fd = 1;
      return 0;
    end
    simplify(neg, fn, fd);
    return 1;
  endfunction

  function void push_result(input bit neg, input logic [63:0] n, input logic [63:0] d,
                            input logic [1:0] ord, input logic [1:0] st, input bit lst);
    result_t r;
    logic [63:0] lim;
    lim = 64'h7FFF_FFFF;
    if (st == rfa_pkg::ST_OK && (n > lim || d > lim)) st = rfa_pkg::ST_OVF;
    if (st != rfa_pkg::ST_OK) begin
      neg = 0;
      n = 0;
      d = 1;
    end
    r.num = neg ? -n[31:0] : n[31:0];
    r.den = d[30:0];
    r.order = ord;
    r.status = st;
    r.last = lst;
    status_count[st]++;
    pending.push_back(r);
  endfunction

  // Work out the results caused by one accepted input item.
  function void note_item(input logic [2:0] kind, input logic [31:0] an,
                          input logic [31:0] ad, input logic [31:0] bn,
                          input logic [31:0] bd);
    bit sa, sb, sr, ok_a, ok_b, sy;
    logic [63:0] na, da, nb, db, nr, dr, x, y;
    logic [1:0] ord;
    items_seen++;
    kind_count[kind]++;
    ok_a = take_operand(an, ad, sa, na, da);
    ok_b = take_operand(bn, bd, sb, nb, db);
    if (kind > rfa_pkg::KIND_RED) return;
    if (kind == rfa_pkg::KIND_RED) begin
      push_result(sa, na, da, rfa_pkg::ORD_LT, ok_a ? rfa_pkg::ST_OK : rfa_pkg::ST_ZDEN, 0);
      push_result(sb, nb, db, rfa_pkg::ORD_LT, ok_b ? rfa_pkg::ST_OK : rfa_pkg::ST_ZDEN, 1);
      return;
    end
    if (!ok_a || !ok_b) begin
      push_result(0, 0, 1, rfa_pkg::ORD_LT, rfa_pkg::ST_ZDEN, 1);
      return;
    end
    x = na * db;
    y = nb * da;
    case (kind)
      rfa_pkg::KIND_ADD, rfa_pkg::KIND_SUB: begin
        sy = sb ^ (kind == rfa_pkg::KIND_SUB);
        if (sa == sy) begin
          nr = x + y;
          sr = sa;
        end else if (x >= y) begin
          nr = x - y;
          sr = sa;
        end else begin
          nr = y - x;
          sr = sy;
        end
        dr = da * db;
      end
      rfa_pkg::KIND_MUL: begin
        sr = sa != sb;
        nr = na * nb;
        dr = da * db;
      end
      rfa_pkg::KIND_DIV: begin
        if (nb == 0) begin
          push_result(0, 0, 1, rfa_pkg::ORD_LT, rfa_pkg::ST_DIV0, 1);
          return;
        end
        sr = sa != sb;
        nr = x;
        dr = da * nb;
      end
      default: begin
        if (sa != sb) ord = sa ? rfa_pkg::ORD_LT : rfa_pkg::ORD_GT;
        else if (x == y) ord = rfa_pkg::ORD_EQ;
        else if (!sa) ord = (x < y) ? rfa_pkg::ORD_LT : rfa_pkg::ORD_GT;
        else ord = (x > y) ? rfa_pkg::ORD_LT : rfa_pkg::ORD_GT;
        push_result(0, 0, 1, ord, rfa_pkg::ST_OK, 1);
        return;
      end
    endcase
    simplify(sr, nr, dr);
    push_result(sr, nr, dr, rfa_pkg::ORD_LT, rfa_pkg::ST_OK, 1);
  endfunction

  // Compare one transfer on the result channel with the oldest expectation.
  function void check_result(input logic signed [31:0] num, input logic [30:0] den,
                             input logic [1:0] ord, input logic [1:0] st, input logic lst);
    result_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %0d/%0d order %0d status %0d last %0d",
               $time, num, den, ord, st, lst);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (num !== e.num) begin
      $display("%0t: res_num expected %0d actual %0d", $time, e.num, num);
      errors++;
    end
    if (den !== e.den) begin
      $display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
      errors++;
    end
    if (ord !== e.order) begin
      $display("%0t: order expected %0d actual %0d", $time, e.order, ord);
      errors++;
    end
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      errors++;
    end
    if (lst !== e.last) begin
      $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
      errors++;
    end
  endfunction
endclass

module testbench;
  import rfa_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         in_kind = '0;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic [1:0]         out_order;
  logic [1:0]         out_status;
  logic               out_last;

  frac_scoreboard fractions = new();
  bit             stim_done = 0;
  bit             hold_off = 0;

  rational_fraction_alu_core DUT (.*);

  always #2 clk = ~clk;

  // Gap length: mostly none or short, occasionally long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Operand value biased toward small magnitudes, extremes and random bits.
  function automatic logic [31:0] pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 40) return $urandom_range(0, 40) - 20;
    if (p < 55) return $urandom_range(0, 2000) - 1000;
    if (p < 62) return 32'h7FFF_FFFF;
    if (p < 67) return 32'h8000_0001;
    if (p < 70) return 32'h8000_0000;
    if (p < 75) return 0;
    if (p < 85) return $urandom_range(0, 65535) * ($urandom_range(1) ? 1 : -1);
    return $urandom;
  endfunction

  // Offer one item and wait for its transfer.
  task automatic send_item(input logic [2:0] k, input logic [31:0] an,
                           input logic [31:0] ad, input logic [31:0] bn,
                           input logic [31:0] bd);
    in_valid <= 1;
    in_kind <= k;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fractions.note_item(k, an, ad, bn, bd);
  endtask

  task automatic idle_sender(input int n);
    if (n == 0) return;
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // Record transfers on the result channel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      fractions.check_result(out_res_num, out_res_den, out_order, out_status, out_last);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= 1;
      n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] ext[6];
    int i;
    ext = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 0, 1, 32'hFFFF_FFFF};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every kind, extremes, zero denominators, divide by zero, overflow.
    send_item(KIND_ADD, 1, 2, 1, 3);
    send_item(KIND_SUB, 1, 2, 1, 2);
    send_item(KIND_MUL, -6, 4, 10, -3);
    send_item(KIND_DIV, 3, 7, 0, 5);
    send_item(KIND_DIV, -2, 3, -4, 9);
    send_item(KIND_CMP, 1, 3, 2, 6);
    send_item(KIND_CMP, -1, 3, 1, 3);
    send_item(KIND_CMP, -1, 2, -1, 3);
    send_item(KIND_RED, 12, -18, 0, -7);
    send_item(KIND_RED, 5, 0, 32'h8000_0000, 1);
    send_item(KIND_ADD, 1, 0, 1, 2);
    send_item(KIND_CMP, 1, 2, 3, 0);
    send_item(KIND_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send_item(KIND_MUL, 32'h7FFF_FFFF, 1, 32'h8000_0001, 1);
    send_item(KIND_SUB, 32'h8000_0001, 32'h7FFF_FFFF, 1, 1);
    send_item(KIND_DIV, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_item(KIND_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(KIND_MUL, 0, -5, 3, 4);
    send_item(3'd6, 1, 1, 1, 1);
    send_item(3'd7, 2, 3, 4, 5);
    send_item(KIND_RED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
    send_item(KIND_ADD, ext[$urandom_range(5)], 3, 5, ext[$urandom_range(5)]);

    // Random: mostly valid kinds; long hold-off triggered early on.
    for (i = 0; i < 1500; i++) begin
      if (i == 100) hold_off = 1;
      send_item(3'(($urandom_range(19) == 0) ? $urandom_range(6, 7) : $urandom_range(5)),
                pick_value(), pick_value(), pick_value(), pick_value());
      idle_sender(gap_len());
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Finish once nothing is outstanding, plus a drain period.
  initial begin
    wait (stim_done);
    while (fractions.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("Covered %0d items (%0d results): kinds add..reduce %0d %0d %0d %0d %0d %0d.",
             fractions.items_seen, fractions.results_seen, fractions.kind_count[0],
             fractions.kind_count[1], fractions.kind_count[2], fractions.kind_count[3],
             fractions.kind_count[4], fractions.kind_count[5]);
    $display("Statuses ok %0d, zero den %0d, div by zero %0d, overflow %0d.",
             fractions.status_count[0], fractions.status_count[1],
             fractions.status_count[2], fractions.status_count[3]);
    if (fractions.errors == 0 && fractions.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

>>> rational_fraction_alu_core.f
rtl/core/rfa_pkg.sv
rtl/core/rfa_dp.sv
rtl/core/rfa_ctrl.sv
rtl/core/rational_fraction_alu_core.sv
tb/testbench.sv
